[design/tlr_pkg.sv]
// Shared constants, types and state codes of the thick-line rasterizer.
`timescale 1ns / 1ps

package tlr_pkg;

    localparam int COORD_BITS    = 12;
    localparam int SIZE_BITS     = 12;
    localparam int COLOR_BITS    = 24;
    localparam int THICK_BITS    = 3;
    localparam int HALF_BITS     = 2;
    localparam int OFS_BITS      = HALF_BITS + 1;
    localparam int ERR_BITS      = COORD_BITS + 2;
    localparam int ALU_BITS      = ERR_BITS + 1;
    localparam int MAX_THICKNESS = 7;
    localparam int ADDR_BITS     = 3;
    localparam int DATA_BITS     = 32;
    localparam int WIDTH_RESET   = 640;
    localparam int HEIGHT_RESET  = 480;

    localparam logic ACT_START   = 1'b0;
    localparam logic ACT_ADVANCE = 1'b1;

    localparam logic REG_SEL_WIDTH  = 1'b0;
    localparam logic REG_SEL_HEIGHT = 1'b1;

    typedef enum logic [3:0] {
        ST_IDLE,
        ST_SIGN_X,
        ST_DELTA_X,
        ST_SIGN_Y,
        ST_DELTA_Y,
        ST_ERR_INIT,
        ST_EMIT,
        ST_CMP_X,
        ST_CMP_Y,
        ST_UPD_X,
        ST_UPD_Y
    } tlr_state_t;

    typedef struct packed {
        logic signed [ALU_BITS-1:0] a;
        logic signed [ALU_BITS-1:0] b;
        logic                       sub;
    } alu_req_t;

endpackage

[design/thick_line_rasterizer_unit.sv]
// Bresenham line rasterizer with square brush: sequencer, state and output word register.
`timescale 1ns / 1ps

// A start word is taken in idle, then SIGN_X, DELTA_X, SIGN_Y, DELTA_Y and ERR_INIT
// use one shared adder to work out the step directions, the absolute deltas and the
// initial error; the start yields no output. An advance word emits (2*(thickness/2)+1)^2
// brush pixels, 1 to 49, at one pixel per cycle while out_stall is low, then takes
// the Bresenham step in CMP_X, CMP_Y, UPD_X and UPD_Y through the same adder (none
// when the point is the endpoint). in_stall is high from the cycle after a word is
// taken until the sequencer is back in idle. An advance with no line loaded is taken
// and dropped. The last pixel may still wait in the output register while the next
// word is taken. Canvas width and height sit at byte addresses 0 and 4 of the
// register port and should be written while idle.
module thick_line_rasterizer_unit
    import tlr_pkg::*;
(
    input  logic                         clk,
    input  logic                         rst_n,

    input  logic                         psel,
    input  logic                         penable,
    input  logic                         pwrite,
    input  logic [ADDR_BITS-1:0]         paddr,
    input  logic [DATA_BITS-1:0]         pwdata,
    output logic [DATA_BITS-1:0]         prdata,
    output logic                         pready,

    input  logic                         in_valid,
    output logic                         in_stall,
    input  logic                         action,
    input  logic signed [COORD_BITS-1:0] x_start,
    input  logic signed [COORD_BITS-1:0] y_start,
    input  logic signed [COORD_BITS-1:0] x_end,
    input  logic signed [COORD_BITS-1:0] y_end,
    input  logic [THICK_BITS-1:0]        thickness,
    input  logic [COLOR_BITS-1:0]        color_in,

    output logic                         out_valid,
    input  logic                         out_stall,
    output logic signed [COORD_BITS-1:0] pixel_x,
    output logic signed [COORD_BITS-1:0] pixel_y,
    output logic [COLOR_BITS-1:0]        color_out,
    output logic                         on_canvas,
    output logic                         last_of_point,
    output logic                         line_done
);

    tlr_state_t state_reg, state_next;

    logic [SIZE_BITS-1:0]         width_reg, width_next;
    logic [SIZE_BITS-1:0]         height_reg, height_next;

    logic signed [COORD_BITS-1:0] cur_x_reg, cur_x_next;
    logic signed [COORD_BITS-1:0] cur_y_reg, cur_y_next;
    logic signed [COORD_BITS-1:0] end_x_reg, end_x_next;
    logic signed [COORD_BITS-1:0] end_y_reg, end_y_next;
    logic [COORD_BITS-1:0]        delta_x_reg, delta_x_next;
    logic [COORD_BITS-1:0]        delta_y_reg, delta_y_next;
    logic                         step_x_neg_reg, step_x_neg_next;
    logic                         step_y_neg_reg, step_y_neg_next;
    logic signed [ERR_BITS-1:0]   error_reg, error_next;
    logic [HALF_BITS-1:0]         half_reg, half_next;
    logic [COLOR_BITS-1:0]        color_reg, color_next;
    logic                         busy_reg, busy_next;
    logic                         done_reg, done_next;
    logic                         move_x_reg, move_x_next;
    logic                         move_y_reg, move_y_next;
    logic signed [OFS_BITS-1:0]   ofs_x_reg, ofs_x_next;
    logic signed [OFS_BITS-1:0]   ofs_y_reg, ofs_y_next;

    logic                         out_valid_reg, out_valid_next;
    logic signed [COORD_BITS-1:0] pixel_x_reg, pixel_x_next;
    logic signed [COORD_BITS-1:0] pixel_y_reg, pixel_y_next;
    logic [COLOR_BITS-1:0]        color_out_reg, color_out_next;
    logic                         on_canvas_reg, on_canvas_next;
    logic                         last_reg, last_next;
    logic                         line_done_reg, line_done_next;

    alu_req_t                     alu_req;
    logic signed [ALU_BITS-1:0]   alu_sum;

    logic                         cfg_write;
    logic                         in_take;
    logic                         slot_free;
    logic                         emit;
    logic                         ofs_x_at_end;
    logic                         ofs_y_at_end;
    logic signed [OFS_BITS-1:0]   ofs_hi;
    logic signed [OFS_BITS-1:0]   ofs_lo;
    logic signed [COORD_BITS:0]   px_full;
    logic signed [COORD_BITS:0]   py_full;
    logic                         px_on;
    logic                         py_on;
    logic [THICK_BITS-1:0]        thick_sat;
    logic signed [ALU_BITS-1:0]   err_twice;

    tlr_alu u_alu (
        .req (alu_req),
        .sum (alu_sum)
    );

    assign pready    = 1'b1;
    assign cfg_write = psel && penable && pwrite && pready;
    assign prdata    = (paddr[2] == REG_SEL_HEIGHT) ? DATA_BITS'(height_reg)
                                                    : DATA_BITS'(width_reg);

    assign in_take   = in_valid && !in_stall;
    assign slot_free = !out_valid_reg || !out_stall;
    assign emit      = (state_reg == ST_EMIT) && slot_free;

    assign ofs_hi       = $signed({1'b0, half_reg});
    assign ofs_lo       = -ofs_hi;
    assign ofs_x_at_end = (ofs_x_reg == ofs_hi);
    assign ofs_y_at_end = (ofs_y_reg == ofs_hi);

    assign px_full = (COORD_BITS+1)'(cur_x_reg) + (COORD_BITS+1)'(ofs_x_reg);
    assign py_full = (COORD_BITS+1)'(cur_y_reg) + (COORD_BITS+1)'(ofs_y_reg);
    assign px_on   = !px_full[COORD_BITS] &&
                     ($unsigned(px_full) < (COORD_BITS+1)'(width_reg));
    assign py_on   = !py_full[COORD_BITS] &&
                     ($unsigned(py_full) < (COORD_BITS+1)'(height_reg));

    assign thick_sat = (thickness > THICK_BITS'(MAX_THICKNESS)) ?
                       THICK_BITS'(MAX_THICKNESS) : thickness;
    assign err_twice = $signed({error_reg, 1'b0});

    // next state
    always_comb
    begin
        state_next = state_reg;
        case (state_reg)
            ST_IDLE:
            begin
                if (in_valid)
                begin
                    if (action == ACT_START)
                        state_next = ST_SIGN_X;
                    else if (busy_reg)
                        state_next = ST_EMIT;
                end
            end
            ST_SIGN_X:   state_next = ST_DELTA_X;
            ST_DELTA_X:  state_next = ST_SIGN_Y;
            ST_SIGN_Y:   state_next = ST_DELTA_Y;
            ST_DELTA_Y:  state_next = ST_ERR_INIT;
            ST_ERR_INIT: state_next = ST_IDLE;
            ST_EMIT:
            begin
                if (emit && ofs_x_at_end && ofs_y_at_end)
                    state_next = done_reg ? ST_IDLE : ST_CMP_X;
            end
            ST_CMP_X:    state_next = ST_CMP_Y;
            ST_CMP_Y:    state_next = ST_UPD_X;
            ST_UPD_X:    state_next = ST_UPD_Y;
            ST_UPD_Y:    state_next = ST_IDLE;
            default:     state_next = ST_IDLE;
        endcase
    end

    // sequencer outputs: handshake and shared adder operands
    always_comb
    begin
        in_stall    = 1'b1;
        alu_req.a   = '0;
        alu_req.b   = '0;
        alu_req.sub = 1'b0;
        case (state_reg)
            ST_IDLE:
            begin
                in_stall = 1'b0;
            end
            ST_SIGN_X:
            begin
                alu_req.a   = ALU_BITS'(end_x_reg);
                alu_req.b   = ALU_BITS'(cur_x_reg);
                alu_req.sub = 1'b1;
            end
            ST_DELTA_X:
            begin
                alu_req.a   = step_x_neg_reg ? ALU_BITS'(cur_x_reg) : ALU_BITS'(end_x_reg);
                alu_req.b   = step_x_neg_reg ? ALU_BITS'(end_x_reg) : ALU_BITS'(cur_x_reg);
                alu_req.sub = 1'b1;
            end
            ST_SIGN_Y:
            begin
                alu_req.a   = ALU_BITS'(end_y_reg);
                alu_req.b   = ALU_BITS'(cur_y_reg);
                alu_req.sub = 1'b1;
            end
            ST_DELTA_Y:
            begin
                alu_req.a   = step_y_neg_reg ? ALU_BITS'(cur_y_reg) : ALU_BITS'(end_y_reg);
                alu_req.b   = step_y_neg_reg ? ALU_BITS'(end_y_reg) : ALU_BITS'(cur_y_reg);
                alu_req.sub = 1'b1;
            end
            ST_ERR_INIT:
            begin
                alu_req.a   = $signed(ALU_BITS'(delta_x_reg));
                alu_req.b   = $signed(ALU_BITS'(delta_y_reg));
                alu_req.sub = 1'b1;
            end
            ST_CMP_X:
            begin
                alu_req.a   = err_twice;
                alu_req.b   = $signed(ALU_BITS'(delta_y_reg));
                alu_req.sub = 1'b0;
            end
            ST_CMP_Y:
            begin
                alu_req.a   = err_twice;
                alu_req.b   = $signed(ALU_BITS'(delta_x_reg));
                alu_req.sub = 1'b1;
            end
            ST_UPD_X:
            begin
                alu_req.a   = ALU_BITS'(error_reg);
                alu_req.b   = $signed(ALU_BITS'(delta_y_reg));
                alu_req.sub = 1'b1;
            end
            ST_UPD_Y:
            begin
                alu_req.a   = ALU_BITS'(error_reg);
                alu_req.b   = $signed(ALU_BITS'(delta_x_reg));
                alu_req.sub = 1'b0;
            end
            default:
            begin
                in_stall = 1'b1;
            end
        endcase
    end

    // datapath next values
    always_comb
    begin
        width_next      = width_reg;
        height_next     = height_reg;
        cur_x_next      = cur_x_reg;
        cur_y_next      = cur_y_reg;
        end_x_next      = end_x_reg;
        end_y_next      = end_y_reg;
        delta_x_next    = delta_x_reg;
        delta_y_next    = delta_y_reg;
        step_x_neg_next = step_x_neg_reg;
        step_y_neg_next = step_y_neg_reg;
        error_next      = error_reg;
        half_next       = half_reg;
        color_next      = color_reg;
        busy_next       = busy_reg;
        done_next       = done_reg;
        move_x_next     = move_x_reg;
        move_y_next     = move_y_reg;
        ofs_x_next      = ofs_x_reg;
        ofs_y_next      = ofs_y_reg;
        out_valid_next  = out_valid_reg && out_stall;
        pixel_x_next    = pixel_x_reg;
        pixel_y_next    = pixel_y_reg;
        color_out_next  = color_out_reg;
        on_canvas_next  = on_canvas_reg;
        last_next       = last_reg;
        line_done_next  = line_done_reg;

        if (cfg_write)
        begin
            if (paddr[2] == REG_SEL_WIDTH)
                width_next = pwdata[SIZE_BITS-1:0];
            else
                height_next = pwdata[SIZE_BITS-1:0];
        end

        case (state_reg)
            ST_IDLE:
            begin
                if (in_take)
                begin
                    if (action == ACT_START)
                    begin
                        cur_x_next = x_start;
                        cur_y_next = y_start;
                        end_x_next = x_end;
                        end_y_next = y_end;
                        half_next  = thick_sat[THICK_BITS-1:1];
                        color_next = color_in;
                        busy_next  = 1'b1;
                    end
                    else if (busy_reg)
                    begin
                        done_next  = (cur_x_reg == end_x_reg) && (cur_y_reg == end_y_reg);
                        ofs_x_next = ofs_lo;
                        ofs_y_next = ofs_lo;
                    end
                end
            end
            ST_SIGN_X:
                step_x_neg_next = alu_sum[ALU_BITS-1] || (alu_sum == '0);
            ST_DELTA_X:
                delta_x_next = alu_sum[COORD_BITS-1:0];
            ST_SIGN_Y:
                step_y_neg_next = alu_sum[ALU_BITS-1] || (alu_sum == '0);
            ST_DELTA_Y:
                delta_y_next = alu_sum[COORD_BITS-1:0];
            ST_ERR_INIT:
                error_next = alu_sum[ERR_BITS-1:0];
            ST_EMIT:
            begin
                if (emit)
                begin
                    out_valid_next = 1'b1;
                    pixel_x_next   = px_full[COORD_BITS-1:0];
                    pixel_y_next   = py_full[COORD_BITS-1:0];
                    color_out_next = color_reg;
                    on_canvas_next = px_on && py_on;
                    last_next      = ofs_x_at_end && ofs_y_at_end;
                    line_done_next = done_reg;
                    if (ofs_x_at_end)
                    begin
                        ofs_x_next = ofs_lo;
                        ofs_y_next = ofs_y_reg + OFS_BITS'(1);
                        if (ofs_y_at_end && done_reg)
                            busy_next = 1'b0;
                    end
                    else
                    begin
                        ofs_x_next = ofs_x_reg + OFS_BITS'(1);
                    end
                end
            end
            ST_CMP_X:
                move_x_next = !alu_sum[ALU_BITS-1] && (alu_sum != '0);
            ST_CMP_Y:
                move_y_next = alu_sum[ALU_BITS-1];
            ST_UPD_X:
            begin
                if (move_x_reg)
                begin
                    error_next = alu_sum[ERR_BITS-1:0];
                    cur_x_next = step_x_neg_reg ? cur_x_reg - COORD_BITS'(1)
                                                : cur_x_reg + COORD_BITS'(1);
                end
            end
            ST_UPD_Y:
            begin
                if (move_y_reg)
                begin
                    error_next = alu_sum[ERR_BITS-1:0];
                    cur_y_next = step_y_neg_reg ? cur_y_reg - COORD_BITS'(1)
                                                : cur_y_reg + COORD_BITS'(1);
                end
            end
            default:
            begin
                busy_next = busy_reg;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg      <= ST_IDLE;
            width_reg      <= SIZE_BITS'(WIDTH_RESET);
            height_reg     <= SIZE_BITS'(HEIGHT_RESET);
            cur_x_reg      <= '0;
            cur_y_reg      <= '0;
            end_x_reg      <= '0;
            end_y_reg      <= '0;
            delta_x_reg    <= '0;
            delta_y_reg    <= '0;
            step_x_neg_reg <= 1'b0;
            step_y_neg_reg <= 1'b0;
            error_reg      <= '0;
            half_reg       <= '0;
            color_reg      <= '0;
            busy_reg       <= 1'b0;
            done_reg       <= 1'b0;
            move_x_reg     <= 1'b0;
            move_y_reg     <= 1'b0;
            ofs_x_reg      <= '0;
            ofs_y_reg      <= '0;
            out_valid_reg  <= 1'b0;
        end
        else
        begin
            state_reg      <= state_next;
            width_reg      <= width_next;
            height_reg     <= height_next;
            cur_x_reg      <= cur_x_next;
            cur_y_reg      <= cur_y_next;
            end_x_reg      <= end_x_next;
            end_y_reg      <= end_y_next;
            delta_x_reg    <= delta_x_next;
            delta_y_reg    <= delta_y_next;
            step_x_neg_reg <= step_x_neg_next;
            step_y_neg_reg <= step_y_neg_next;
            error_reg      <= error_next;
            half_reg       <= half_next;
            color_reg      <= color_next;
            busy_reg       <= busy_next;
            done_reg       <= done_next;
            move_x_reg     <= move_x_next;
            move_y_reg     <= move_y_next;
            ofs_x_reg      <= ofs_x_next;
            ofs_y_reg      <= ofs_y_next;
            out_valid_reg  <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        pixel_x_reg   <= pixel_x_next;
        pixel_y_reg   <= pixel_y_next;
        color_out_reg <= color_out_next;
        on_canvas_reg <= on_canvas_next;
        last_reg      <= last_next;
        line_done_reg <= line_done_next;
    end

    assign out_valid     = out_valid_reg;
    assign pixel_x       = pixel_x_reg;
    assign pixel_y       = pixel_y_reg;
    assign color_out     = color_out_reg;
    assign on_canvas     = on_canvas_reg;
    assign last_of_point = last_reg;
    assign line_done     = line_done_reg;

endmodule

[design/tlr_alu.sv]
// Shared add/subtract unit used by the rasterizer sequencer.
`timescale 1ns / 1ps

module tlr_alu
    import tlr_pkg::*;
(
    input  alu_req_t                   req,
    output logic signed [ALU_BITS-1:0] sum
);

    logic [ALU_BITS-1:0] b_op;

    assign b_op = req.sub ? ~req.b : req.b;
    assign sum  = req.a + $signed(b_op) + $signed(ALU_BITS'(req.sub));

endmodule
